// ===== sv/gpvu_pkg.sv =====
`default_nettype none
package gpvu_pkg;

	localparam int VW       = 32;
	localparam int FB       = 16;
	localparam int SQ_W     = 66;
	localparam int ROOT_W   = 33;
	localparam int SQ_STEPS = 33;
	localparam int U_STEPS  = 17;
	localparam int F_STEPS  = 64;
	localparam int N_ITER   = F_STEPS;

	typedef enum logic [1:0] {
		REG_GRAV  = 2'd0,
		REG_TSTEP = 2'd1,
		REG_SOFT  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic                pass;
		logic [VW-1:0]       v1x, v1y, v2x, v2y;
		logic [VW-1:0]       m1, m2;
		logic                nx, ny;
		logic [VW-1:0]       dxm, dym;
		logic [63:0]         dx2, dy2;
		logic [63:0]         gt;
		logic [SQ_W-1:0]     sq;
		logic [47:0]         ph1, ph2;
		logic [63:0]         pl1, pl2;
		logic [63:0]         c1, c2;
		logic [35:0]         srem;
		logic [ROOT_W-1:0]   sroot;
		logic [33:0]         uxr, uyr;
		logic [16:0]         uxq, uyq;
		logic [SQ_W:0]       f1r, f2r;
		logic [63:0]         f1q, f2q;
		logic                f1s, f2s;
	} pipe_t;

	typedef struct packed {
		logic                pass;
		logic                ovf;
		logic [3:0][VW-1:0]  v;
		logic [3:0]          neg;
		logic [3:0][48:0]    ah;
		logic [3:0][48:0]    al;
		logic [3:0][33:0]    dm;
	} post_t;

	// one restoring step of the direction divide: {quotient bit, remainder}
	function automatic logic [34:0] udiv_step(input logic [33:0] rem, input logic nb,
			input logic [ROOT_W-1:0] d);
		logic [33:0] t;
		t = {rem[32:0], nb};
		if (t >= {1'b0, d}) begin
			udiv_step = {1'b1, t - {1'b0, d}};
		end else begin
			udiv_step = {1'b0, t};
		end
	endfunction

	// one restoring step of the force divide: {quotient bit, remainder}
	function automatic logic [SQ_W+1:0] fdiv_step(input logic [SQ_W:0] rem, input logic nb,
			input logic [SQ_W-1:0] d);
		logic [SQ_W:0] t;
		t = {rem[SQ_W-1:0], nb};
		if (t >= {1'b0, d}) begin
			fdiv_step = {1'b1, t - {1'b0, d}};
		end else begin
			fdiv_step = {1'b0, t};
		end
	endfunction

	// iteration stage k: root digit, direction quotient bit, force quotient bit
	function automatic pipe_t iter_step(input pipe_t p, input int unsigned k);
		pipe_t             r;
		logic [SQ_W-1:0]   sh;
		logic [35:0]       srm;
		logic [35:0]       trial;
		logic [34:0]       ux, uy;
		logic [SQ_W+1:0]   fa, fb;
		logic [SQ_W:0]     r1, r2;
		logic              nb;
		r = p;
		if (k < SQ_STEPS) begin
			sh = p.sq >> 7'(64 - 2 * k);
			srm = {p.srem[33:0], sh[1:0]};
			trial = {1'b0, p.sroot, 2'b01};
			if (srm >= trial) begin
				r.srem = srm - trial;
				r.sroot = {p.sroot[ROOT_W-2:0], 1'b1};
			end else begin
				r.srem = srm;
				r.sroot = {p.sroot[ROOT_W-2:0], 1'b0};
			end
		end
		if (k == SQ_STEPS) begin
			ux = udiv_step({3'b0, p.dxm[VW-1:1]}, p.dxm[0], p.sroot);
			uy = udiv_step({3'b0, p.dym[VW-1:1]}, p.dym[0], p.sroot);
			r.uxq = {16'b0, ux[34]};
			r.uyq = {16'b0, uy[34]};
			r.uxr = ux[33:0];
			r.uyr = uy[33:0];
		end else if (k > SQ_STEPS && k < SQ_STEPS + U_STEPS) begin
			ux = udiv_step(p.uxr, 1'b0, p.sroot);
			uy = udiv_step(p.uyr, 1'b0, p.sroot);
			r.uxq = {p.uxq[15:0], ux[34]};
			r.uyq = {p.uyq[15:0], uy[34]};
			r.uxr = ux[33:0];
			r.uyr = uy[33:0];
		end
		if (k == 0) begin
			r1 = {35'b0, p.c1[63:32]};
			r2 = {35'b0, p.c2[63:32]};
			r.f1s = (p.sq[SQ_W-1:32] == '0) && (p.c1 >= {p.sq[31:0], 32'b0});
			r.f2s = (p.sq[SQ_W-1:32] == '0) && (p.c2 >= {p.sq[31:0], 32'b0});
			r.f1q = '0;
			r.f2q = '0;
		end else begin
			r1 = p.f1r;
			r2 = p.f2r;
		end
		nb = (k < 32) ? p.c1[5'(31 - k)] : 1'b0;
		fa = fdiv_step(r1, nb, p.sq);
		nb = (k < 32) ? p.c2[5'(31 - k)] : 1'b0;
		fb = fdiv_step(r2, nb, p.sq);
		r.f1q = {r.f1q[62:0], fa[SQ_W+1]};
		r.f2q = {r.f2q[62:0], fb[SQ_W+1]};
		r.f1r = fa[SQ_W:0];
		r.f2r = fb[SQ_W:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/gravity_pair_velocity_update_core.sv =====
// Depth: 72 register stages (front s1..s5, the iteration stages, back s70..s72).
// Throughput: one pair per cycle unless m_tready stalls the output register;
// 64 iteration stages of the force divide set the depth.
// Stall: the whole pipeline holds while the output register waits on m_tready.
// Reset: arst_n clears all stage valid bits and loads the register defaults
// (grav_const 10.0, time_step 0.01, softening 0.1); no clearing pass.
`default_nettype none
module gravity_pair_velocity_update_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
	// second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_mass
	input  wire logic [319:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// first_new_vel_x, first_new_vel_y, second_new_vel_x, second_new_vel_y
	output logic [127:0]      m_tdata,
	// overflow
	output logic              m_tuser,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [31:0] grav_q, tstep_q, soft_q;
	gpvu_pkg::reg_idx_t widx;

	// Pipeline registers: front stages 1..5, iteration stages, back stages.
	gpvu_pkg::pipe_t p_s1, p_s2, p_s3, p_s4, p_s5;
	gpvu_pkg::pipe_t it_s [gpvu_pkg::N_ITER];
	gpvu_pkg::pipe_t chain_in [gpvu_pkg::N_ITER];
	gpvu_pkg::post_t pm_s70, pd_s71, po_s72;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s70, v_s71, v_s72;
	logic [gpvu_pkg::N_ITER-1:0] it_v_s;
	logic en;

	// next contents of the front and back stages
	gpvu_pkg::pipe_t front1_w, front2_w, front3_w, front4_w, front5_w;
	gpvu_pkg::post_t mul_w, clamp_w, out_w;

	logic [32:0] dxs, dys;
	logic [3:0][63:0] f_w;
	logic [3:0][16:0] u_w;
	logic [3:0][80:0] full_w;
	logic [3:0][64:0] dv_w;
	logic [3:0][35:0] sum_w;
	logic [3:0][31:0] res_w;
	logic [3:0] sat_w;
	logic dv_ovf_w;
	gpvu_pkg::pipe_t last;

	// The whole pipe advances whenever the output register is free or drained.
	assign en       = !v_s72 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s72;
	assign m_tdata  = {po_s72.v[3], po_s72.v[2], po_s72.v[1], po_s72.v[0]};
	assign m_tuser  = po_s72.ovf;
	assign pready   = 1'b1;

	// ---------------- configuration port ----------------
	assign widx = gpvu_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q  <= 32'd655360;
			tstep_q <= 32'd655;
			soft_q  <= 32'd6554;
		end else if (psel && penable && pwrite) begin
			unique case (widx)
				gpvu_pkg::REG_GRAV:  grav_q  <= pwdata;
				gpvu_pkg::REG_TSTEP: tstep_q <= pwdata;
				gpvu_pkg::REG_SOFT:  soft_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			gpvu_pkg::REG_GRAV:  prdata = grav_q;
			gpvu_pkg::REG_TSTEP: prdata = tstep_q;
			gpvu_pkg::REG_SOFT:  prdata = soft_q;
			default:             prdata = '0;
		endcase
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			it_v_s <= '0;
			v_s70  <= 1'b0;
			v_s71  <= 1'b0;
			v_s72  <= 1'b0;
		end else if (en) begin
			v_s1   <= s_tvalid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			it_v_s <= {it_v_s[gpvu_pkg::N_ITER-2:0], v_s5};
			v_s70  <= it_v_s[gpvu_pkg::N_ITER-1];
			v_s71  <= v_s70;
			v_s72  <= v_s71;
		end
	end

	// ---------------- front stages ----------------
	// Offsets as sign and magnitude, body one to body two.
	assign dxs = {s_tdata[191], s_tdata[191:160]} - {s_tdata[31], s_tdata[31:0]};
	assign dys = {s_tdata[223], s_tdata[223:192]} - {s_tdata[63], s_tdata[63:32]};

	always_comb begin
		front1_w      = '0;
		front1_w.v1x  = s_tdata[95:64];
		front1_w.v1y  = s_tdata[127:96];
		front1_w.m1   = s_tdata[159:128];
		front1_w.v2x  = s_tdata[255:224];
		front1_w.v2y  = s_tdata[287:256];
		front1_w.m2   = s_tdata[319:288];
		front1_w.pass = (s_tdata[159:128] == '0) || (s_tdata[319:288] == '0);
		front1_w.nx   = dxs[32];
		front1_w.ny   = dys[32];
		front1_w.dxm  = dxs[32] ? 32'(-dxs) : dxs[31:0];
		front1_w.dym  = dys[32] ? 32'(-dys) : dys[31:0];

		// squares and the product of the two step constants
		front2_w     = p_s1;
		front2_w.dx2 = 64'(p_s1.dxm) * 64'(p_s1.dxm);
		front2_w.dy2 = 64'(p_s1.dym) * 64'(p_s1.dym);
		front2_w.gt  = 64'(grav_q) * 64'(tstep_q);

		// softened squared distance, cannot overflow 66 bits
		front3_w    = p_s2;
		front3_w.sq = 66'(p_s2.dx2) + 66'(p_s2.dy2) + 66'({soft_q, 16'b0});

		// gdt times mass, split into 16- and 32-bit partial products
		front4_w      = p_s3;
		front4_w.pass = p_s3.pass || (p_s3.sq == '0);
		front4_w.ph1  = 48'(p_s3.gt[63:48]) * 48'(p_s3.m2);
		front4_w.pl1  = 64'(p_s3.gt[47:16]) * 64'(p_s3.m2);
		front4_w.ph2  = 48'(p_s3.gt[63:48]) * 48'(p_s3.m1);
		front4_w.pl2  = 64'(p_s3.gt[47:16]) * 64'(p_s3.m1);

		front5_w       = p_s4;
		front5_w.c1    = 64'(({p_s4.ph1, 32'b0} + 80'(p_s4.pl1)) >> 16);
		front5_w.c2    = 64'(({p_s4.ph2, 32'b0} + 80'(p_s4.pl2)) >> 16);
		front5_w.srem  = '0;
		front5_w.sroot = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= front1_w;
			p_s2 <= front2_w;
			p_s3 <= front3_w;
			p_s4 <= front4_w;
			p_s5 <= front5_w;
		end
	end

	// ---------------- iteration stages ----------------
	// Root digits in the first 33, direction bits next 17, force bits in all 64.
	assign chain_in[0] = p_s5;
	for (genvar g = 0; g < gpvu_pkg::N_ITER; g++) begin : g_iter
		if (g > 0) begin : g_link
			assign chain_in[g] = it_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				it_s[g] <= gpvu_pkg::iter_step(chain_in[g], g);
			end
		end
	end

	// ---------------- back stages ----------------
	assign last = it_s[gpvu_pkg::N_ITER-1];
	assign f_w[0] = last.f1s ? '1 : last.f1q;
	assign f_w[1] = last.f1s ? '1 : last.f1q;
	assign f_w[2] = last.f2s ? '1 : last.f2q;
	assign f_w[3] = last.f2s ? '1 : last.f2q;
	assign u_w[0] = last.uxq;
	assign u_w[1] = last.uyq;
	assign u_w[2] = last.uxq;
	assign u_w[3] = last.uyq;

	always_comb begin
		dv_ovf_w = 1'b0;
		for (int i = 0; i < 4; i++) begin
			full_w[i] = {pm_s70.ah[i], 32'b0} + 81'(pm_s70.al[i]);
			dv_w[i] = full_w[i][80:16];
			dv_ovf_w = dv_ovf_w | dv_w[i][64];
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum_w[i] = pd_s71.neg[i]
				? {{4{pd_s71.v[i][31]}}, pd_s71.v[i]} - 36'(pd_s71.dm[i])
				: {{4{pd_s71.v[i][31]}}, pd_s71.v[i]} + 36'(pd_s71.dm[i]);
			sat_w[i] = 1'b1;
			if (!sum_w[i][35] && sum_w[i][34:31] != 4'h0) begin
				res_w[i] = 32'h7fff_ffff;
			end else if (sum_w[i][35] && sum_w[i][34:31] != 4'hf) begin
				res_w[i] = 32'h8000_0000;
			end else begin
				res_w[i] = sum_w[i][31:0];
				sat_w[i] = 1'b0;
			end
		end
	end

	always_comb begin
		// dv partial products: force halves times the unit direction
		mul_w      = '0;
		mul_w.pass = last.pass;
		mul_w.ovf  = last.f1s || last.f2s;
		mul_w.v    = {last.v2y, last.v2x, last.v1y, last.v1x};
		mul_w.neg  = {!last.ny, !last.nx, last.ny, last.nx};
		for (int i = 0; i < 4; i++) begin
			mul_w.ah[i] = 49'(f_w[i][63:32]) * 49'(u_w[i]);
			mul_w.al[i] = 49'(f_w[i][31:0]) * 49'(u_w[i]);
		end

		// clamp dv at 2^33: any larger step saturates the velocity anyway
		clamp_w     = pm_s70;
		clamp_w.ovf = pm_s70.ovf || dv_ovf_w;
		for (int i = 0; i < 4; i++) begin
			clamp_w.dm[i] = (dv_w[i][64:33] != '0) ? 34'h2_0000_0000
				: {1'b0, dv_w[i][32:0]};
		end

		// pass-through pairs keep their velocities and flag overflow
		out_w = pd_s71;
		if (pd_s71.pass) begin
			out_w.ovf = 1'b1;
		end else begin
			out_w.v   = res_w;
			out_w.ovf = pd_s71.ovf || (sat_w != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s70 <= mul_w;
			pd_s71 <= clamp_w;
			po_s72 <= out_w;
		end
	end

`ifndef SYNTHESIS
	a_hold_s70: assert property (@(posedge clk) disable iff (!arst_n)
		!en && v_s70 |=> v_s70)
		else $error("stage 70 lost a word during a stall");
	a_move_iter: assert property (@(posedge clk) disable iff (!arst_n)
		en && it_v_s[gpvu_pkg::N_ITER-1] |=> v_s70)
		else $error("word dropped leaving the iteration stages");
	a_move_front: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted word missing from stage 1");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s71 |-> (pd_s71.dm[0] <= 34'h2_0000_0000) && (pd_s71.dm[3] <= 34'h2_0000_0000))
		else $error("velocity step clamp out of range");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb;

	// one particle pair as it travels on s_tdata
	typedef struct packed {
		logic [31:0] m2, v2y, v2x, y2, x2;
		logic [31:0] m1, v1y, v1x, y1, x1;
	} pair_t;

	// one result word: new velocities and the overflow flag
	typedef struct packed {
		logic        ovf;
		logic [31:0] v2y, v2x, v1y, v1x;
	} vel_t;

	// directed row: pair, whether the result is typed in, and that result
	typedef struct {
		pair_t p;
		bit    typed;
		vel_t  res;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [319:0] s_tdata;   // x1, y1, v1x, v1y, m1, x2, y2, v2x, v2y, m2 (lowest first)
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // v1x, v1y, v2x, v2y (lowest first)
	logic         m_tuser;   // overflow
	logic         psel, penable, pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	// shadow copies of the block registers
	logic [31:0] grav_sh, step_sh, soft_sh;

	vel_t        pending_vel[$];
	bit          typed_q[$];
	vel_t        typed_res_q[$];
	int          mismatches;
	bit          hold_req;

	gravity_pair_velocity_update_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// clamp a 64-bit intermediate, flag when it does not fit
	function automatic logic [63:0] clamp64(input logic [127:0] x, inout bit ovf);
		if (x[127:64] != '0) begin
			ovf = 1'b1;
			return '1;
		end
		return x[63:0];
	endfunction

	// velocity plus signed delta, saturated to the 32-bit signed range
	function automatic logic [31:0] nudge_vel(input logic [31:0] v, input bit dneg,
			input logic [63:0] dmag, inout bit ovf);
		logic signed [67:0] s, dd, r;
		s = $signed({{36{v[31]}}, v});
		dd = $signed({4'b0, dmag});
		r = dneg ? s - dd : s + dd;
		if (r > 68'sh7fff_ffff) begin
			ovf = 1'b1;
			return 32'h7fff_ffff;
		end
		if (r < -68'sh8000_0000) begin
			ovf = 1'b1;
			return 32'h8000_0000;
		end
		return r[31:0];
	endfunction

	// softened pairwise pull over one step
	function automatic vel_t pull_pair(input pair_t p);
		vel_t              r;
		bit                ovf, nx, ny;
		logic signed [33:0] ddx, ddy;
		logic [63:0]       dxm, dym, root, c, ux, uy, gdt, c1, c2, f1, f2;
		logic [127:0]      sq;
		r.v1x = p.v1x;
		r.v1y = p.v1y;
		r.v2x = p.v2x;
		r.v2y = p.v2y;
		r.ovf = 1'b1;
		ovf = 1'b0;
		if (p.m1 == 0 || p.m2 == 0) return r;
		ddx = $signed({{2{p.x2[31]}}, p.x2}) - $signed({{2{p.x1[31]}}, p.x1});
		ddy = $signed({{2{p.y2[31]}}, p.y2}) - $signed({{2{p.y1[31]}}, p.y1});
		nx = ddx < 0;
		ny = ddy < 0;
		dxm = nx ? 64'(-ddx) : 64'(ddx);
		dym = ny ? 64'(-ddy) : 64'(ddy);
		sq = {64'b0, dxm} * {64'b0, dxm} + {64'b0, dym} * {64'b0, dym}
			+ ({96'b0, soft_sh} << gpvu_pkg::FB);
		if (sq == 0) return r;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			c = root | (64'd1 << b);
			if (sq >= {64'b0, c} * {64'b0, c}) root = c;
		end
		ux = clamp64(({64'b0, dxm} << gpvu_pkg::FB) / {64'b0, root}, ovf);
		uy = clamp64(({64'b0, dym} << gpvu_pkg::FB) / {64'b0, root}, ovf);
		gdt = clamp64(({96'b0, grav_sh} * {96'b0, step_sh}) >> gpvu_pkg::FB, ovf);
		c1 = clamp64(({64'b0, gdt} * {96'b0, p.m2}) >> gpvu_pkg::FB, ovf);
		c2 = clamp64(({64'b0, gdt} * {96'b0, p.m1}) >> gpvu_pkg::FB, ovf);
		f1 = clamp64(({64'b0, c1} << (2 * gpvu_pkg::FB)) / sq, ovf);
		f2 = clamp64(({64'b0, c2} << (2 * gpvu_pkg::FB)) / sq, ovf);
		r.v1x = nudge_vel(p.v1x, nx,
			clamp64(({64'b0, f1} * {64'b0, ux}) >> gpvu_pkg::FB, ovf), ovf);
		r.v1y = nudge_vel(p.v1y, ny,
			clamp64(({64'b0, f1} * {64'b0, uy}) >> gpvu_pkg::FB, ovf), ovf);
		r.v2x = nudge_vel(p.v2x, !nx,
			clamp64(({64'b0, f2} * {64'b0, ux}) >> gpvu_pkg::FB, ovf), ovf);
		r.v2y = nudge_vel(p.v2y, !ny,
			clamp64(({64'b0, f2} * {64'b0, uy}) >> gpvu_pkg::FB, ovf), ovf);
		r.ovf = ovf;
		return r;
	endfunction

	// position or velocity: extremes, small values and full-range noise
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3, 4, 5: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_mass();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			2, 3, 4, 5, 6, 7, 8, 9, 10: return $urandom_range(1, 32'h0008_0000);
			default: return $urandom;
		endcase
	endfunction

	// mostly close pairs so the pull is visible; coincide sometimes when asked
	function automatic pair_t pick_pair(input bit allow_coincide);
		pair_t p;
		p.x1 = pick_coord();
		p.y1 = pick_coord();
		p.v1x = pick_coord();
		p.v1y = pick_coord();
		p.v2x = pick_coord();
		p.v2y = pick_coord();
		p.m1 = pick_mass();
		p.m2 = pick_mass();
		if (allow_coincide && $urandom_range(0, 7) == 0) begin
			p.x2 = p.x1;
			p.y2 = p.y1;
		end else if ($urandom_range(0, 2) != 0) begin
			p.x2 = p.x1 + 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
			p.y2 = p.y1 + 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		end else begin
			p.x2 = pick_coord();
			p.y2 = pick_coord();
		end
		return p;
	endfunction

	// the result when the pull is skipped: velocities pass, flag set
	function automatic vel_t unpulled(input pair_t p);
		vel_t r;
		r.v1x = p.v1x;
		r.v1y = p.v1y;
		r.v2x = p.v2x;
		r.v2y = p.v2y;
		r.ovf = 1'b1;
		return r;
	endfunction

	// setup then access; the register takes the value on the access edge
	task automatic write_reg(input gpvu_pkg::reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			gpvu_pkg::REG_GRAV:  grav_sh = val;
			gpvu_pkg::REG_TSTEP: step_sh = val;
			default:             soft_sh = val;
		endcase
	endtask

	// offer one word, hold it until taken, then idle a random gap
	task automatic send_pair(input pair_t p, input bit typed, input vel_t res);
		int gap;
		s_tdata <= p;
		s_tvalid <= 1'b1;
		typed_q.insert(typed_q.size(), typed);
		typed_res_q.insert(typed_res_q.size(), res);
		do @(posedge clk); while (!s_tready);
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: gap = 0;
			19: gap = $urandom_range(20, 80);
			default: gap = $urandom_range(1, 4);
		endcase
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// let the pipe drain before touching the registers
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_vel.size() != 0 || typed_q.size() != 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic random_run(input int count, input bit allow_coincide);
		vel_t nothing;
		nothing = '0;
		for (int i = 0; i < count; i++) begin
			if (i == count / 3) hold_req = 1'b1;
			if (i == (2 * count) / 3) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending_vel.size() != 0 || typed_q.size() != 0);
			end
			send_pair(pick_pair(allow_coincide), 1'b0, nothing);
		end
	endtask

	// predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		vel_t want, got;
		if (arst_n && s_tvalid && s_tready) begin
			want = pull_pair(pair_t'(s_tdata));
			if (typed_q.size() != 0) begin
				if (typed_q[0]) want = typed_res_q[0];
				void'(typed_q.pop_front());
				void'(typed_res_q.pop_front());
			end
			pending_vel.insert(pending_vel.size(), want);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata};
			if (pending_vel.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", got);
			end else begin
				want = pending_vel.pop_front();
				if (got.v1x !== want.v1x || got.v1y !== want.v1y || got.v2x !== want.v2x
						|| got.v2y !== want.v2y || got.ovf !== want.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp v1 %h %h v2 %h %h ovf %b, got v1 %h %h v2 %h %h ovf %b",
							want.v1x, want.v1y, want.v2x, want.v2y, want.ovf,
							got.v1x, got.v1y, got.v2x, got.v2y, got.ovf);
				end
			end
		end
	end

	// receiver: random short stalls, rare long ones, and a long hold-off on request
	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = 300;
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				case ($urandom_range(0, 29))
					0: stall = $urandom_range(20, 100);
					1, 2, 3, 4: stall = $urandom_range(1, 3);
					default: stall = 0;
				endcase
				m_tready <= (stall == 0);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("[gravity_pair_velocity_update_core] ERROR");
		$finish;
	end

	initial begin
		row_t  rows[$];
		pair_t p;
		vel_t  nothing;
		nothing = '0;
		mismatches = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		grav_sh = 32'd655360;
		step_sh = 32'd655;
		soft_sh = 32'd6554;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// zero mass: velocities pass and the flag is set
		p = '{m2: 32'h0001_0000, v2y: 32'h8000_0000, v2x: 32'h7fff_ffff, y2: 32'h0001_0000,
			x2: 32'h0002_0000, m1: 32'h0, v1y: 32'h1234_5678, v1x: 32'hffff_0000,
			y1: 32'h0, x1: 32'h0};
		rows.insert(rows.size(), row_t'{p, 1'b1, unpulled(p)});
		p.m1 = 32'hffff_ffff;
		p.m2 = 32'h0;
		p.v1x = 32'h8000_0000;
		p.v1y = 32'h7fff_ffff;
		rows.insert(rows.size(), row_t'{p, 1'b1, unpulled(p)});
		p = '{m2: 32'h0, v2y: 32'hffff_ffff, v2x: 32'h0, y2: 32'h7fff_ffff,
			x2: 32'h8000_0000, m1: 32'h0, v1y: 32'h0, v1x: 32'hffff_ffff,
			y1: 32'h8000_0000, x1: 32'h7fff_ffff};
		rows.insert(rows.size(), row_t'{p, 1'b1, unpulled(p)});
		// extremes of offset, masses and velocities
		p = '{m2: 32'h0001_0000, v2y: 32'h0, v2x: 32'h0, y2: 32'h7fff_ffff,
			x2: 32'h7fff_ffff, m1: 32'h0001_0000, v1y: 32'h0, v1x: 32'h0,
			y1: 32'h8000_0000, x1: 32'h8000_0000};
		rows.insert(rows.size(), row_t'{p, 1'b0, nothing});
		p.x1 = 32'h7fff_ffff;
		p.x2 = 32'h8000_0000;
		rows.insert(rows.size(), row_t'{p, 1'b0, nothing});
		p = '{m2: 32'hffff_ffff, v2y: 32'h7fff_ffff, v2x: 32'h8000_0000, y2: 32'h0000_0100,
			x2: 32'h0000_0100, m1: 32'hffff_ffff, v1y: 32'h8000_0000, v1x: 32'h7fff_ffff,
			y1: 32'h0, x1: 32'h0};
		rows.insert(rows.size(), row_t'{p, 1'b0, nothing});
		p.x2 = 32'h0;
		p.y2 = 32'h0;
		rows.insert(rows.size(), row_t'{p, 1'b0, nothing});
		p = '{m2: 32'h0002_0000, v2y: 32'hffff_8000, v2x: 32'h0000_4000, y2: 32'hfffd_0000,
			x2: 32'hfffe_0000, m1: 32'h0005_0000, v1y: 32'h0001_0000, v1x: 32'hffff_0000,
			y1: 32'h0001_0000, x1: 32'h0003_0000};
		rows.insert(rows.size(), row_t'{p, 1'b0, nothing});
		p.x2 = 32'h0013_0000;
		p.y2 = 32'h0011_0000;
		rows.insert(rows.size(), row_t'{p, 1'b0, nothing});
		p = '1;
		rows.insert(rows.size(), row_t'{p, 1'b0, nothing});
		foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].res);
		random_run(350, 1'b0);
		drain();

		// no softening: coincident bodies skip the pull and flag it
		write_reg(gpvu_pkg::REG_SOFT, 32'h0);
		p = '{m2: 32'h0001_0000, v2y: 32'h0000_0003, v2x: 32'h8000_0000, y2: 32'h0042_0000,
			x2: 32'hff00_0000, m1: 32'h0003_0000, v1y: 32'h7fff_ffff, v1x: 32'h0000_0005,
			y1: 32'h0042_0000, x1: 32'hff00_0000};
		send_pair(p, 1'b1, unpulled(p));
		p.x1 = 32'h8000_0000;
		p.x2 = 32'h8000_0000;
		p.m1 = 32'hffff_ffff;
		p.m2 = 32'hffff_ffff;
		send_pair(p, 1'b1, unpulled(p));
		random_run(350, 1'b1);
		drain();

		write_reg(gpvu_pkg::REG_GRAV, 32'hffff_ffff);
		write_reg(gpvu_pkg::REG_TSTEP, 32'hffff_ffff);
		random_run(350, 1'b1);
		drain();

		write_reg(gpvu_pkg::REG_GRAV, 32'h0);
		write_reg(gpvu_pkg::REG_SOFT, 32'hffff_ffff);
		random_run(350, 1'b0);
		drain();

		write_reg(gpvu_pkg::REG_GRAV, $urandom);
		write_reg(gpvu_pkg::REG_TSTEP, $urandom_range(0, 32'h0001_0000));
		write_reg(gpvu_pkg::REG_SOFT, $urandom_range(0, 32'h0004_0000));
		random_run(350, 1'b1);
		drain();

		if (mismatches == 0 && pending_vel.size() == 0) begin
			$display("[gravity_pair_velocity_update_core] OK");
		end else begin
			$display("[gravity_pair_velocity_update_core] ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
